// File: hdl/lpp_pkg.sv
// Package for the lift position PID: types, register codes and arithmetic constants.
package lpp_pkg;

	localparam int DECAY_Q8   = 205;
	localparam int DEADBAND   = 5;
	localparam int DRIVE_MAX  = 100;
	localparam int DIV_STEPS  = 24;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT_BOTTOM = 3'd0,
		REG_LIMIT_TOP    = 3'd1,
		REG_GAIN_P_UP    = 3'd2,
		REG_GAIN_I_UP    = 3'd3,
		REG_GAIN_D_UP    = 3'd4,
		REG_GAIN_P_DOWN  = 3'd5,
		REG_GAIN_I_DOWN  = 3'd6,
		REG_GAIN_D_DOWN  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic        [9:0]  elapsed_ms;
		logic signed [7:0]  manual_request;
		logic               load_target;
		logic signed [15:0] preset_target;
	} lpp_tick_t;

	typedef struct packed {
		logic signed [7:0]  drive_power;
		logic               moving_down;
		logic               manual_active;
		logic               power_saturated;
		logic signed [15:0] target_now;
	} lpp_result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DEC_HI,
		ST_DEC_LO,
		ST_LEAK,
		ST_P,
		ST_I_HI,
		ST_I_LO,
		ST_D,
		ST_DIV,
		ST_ADD_D,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_ERR,
		OP_DEC_HI,
		OP_DEC_LO,
		OP_LEAK,
		OP_P,
		OP_I_HI,
		OP_I_LO,
		OP_D,
		OP_DIV,
		OP_ADD_D,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t op;
	} lpp_cmd_t;

	typedef struct packed {
		logic manual;
	} lpp_status_t;

endpackage

// File: hdl/lpp_tick_if.sv
// Tick request channel: valid/ready handshake with one control tick as payload.
interface lpp_tick_if;
	logic                 valid;
	logic                 ready;
	lpp_pkg::lpp_tick_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lpp_result_if.sv
// Result request channel: valid/ready handshake with one drive result as payload.
interface lpp_result_if;
	logic                 valid;
	logic                 ready;
	lpp_pkg::lpp_result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/lift_position_pid.sv
// Top level of the lift position PID controller.
// Usage:
//  - tick (sink): one control request per tick: position, elapsed_ms, manual_request,
//    load_target, preset_target. Taken when tick.valid and tick.ready are high.
//  - result (source): one result request per tick: drive_power, moving_down,
//    manual_active, power_saturated, target_now.
//  - cfg_we/cfg_index/cfg_data: register writes, taken on any edge with cfg_we high;
//    write only while no tick is in flight.
// Sequence: a manual tick goes from acceptance through the error step straight to the
//  output step; a PID tick runs through the shared 21x21 multiplier (7 products in
//  turn) and the 2-bit-per-cycle divider for the derivative term (24 steps). The next
//  tick is accepted the cycle after the result is registered.
// The result sits in an output register, so a new tick is taken while the previous
//  result still waits; if the receiver stalls and the register is still full when
//  the next result is ready, the sequencer waits in its last step.
// Reset (arst_n low): limits and gains go to their defaults, the held target, last
//  error and leaky integral clear, the down flag sets, and no result is pending.
module lift_position_pid (
	input  logic                           clk,
	input  logic                           arst_n,
	lpp_tick_if.sink                       tick,
	lpp_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [lpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lpp_pkg::CFG_DATA_W-1:0] cfg_data
);

	lpp_pkg::lpp_cmd_t    cmd;
	lpp_pkg::lpp_status_t status;

	lpp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick.valid),
		.tick_ready   (tick.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	lpp_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.tick_data   (tick.data),
		.result_data (result.data)
	);

`ifndef ASSERT_OFF
	// one tick at a time: no request is taken right after another
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> !tick.ready)
		else $error("tick accepted back to back");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.drive_power <= 8'sd100 &&
			result.data.drive_power >= -8'sd100))
		else $error("drive out of range");

	a_deadband: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.drive_power == 8'sd0 ||
			result.data.drive_power >= 8'sd5 || result.data.drive_power <= -8'sd5))
		else $error("drive inside deadband");

	a_manual_not_down: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.manual_active) |-> !result.data.moving_down)
		else $error("manual result flagged as moving down");
`endif

endmodule

// File: hdl/lpp_datapath.sv
// Datapath of the lift PID: config registers, state, shared multiplier and divider.
module lpp_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lpp_pkg::lpp_cmd_t                cmd,
	output lpp_pkg::lpp_status_t             status,
	input  logic                             cfg_we,
	input  logic [lpp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  lpp_pkg::lpp_tick_t               tick_data,
	output lpp_pkg::lpp_result_t             result_data
);

	logic signed [15:0] lim_bot_q, lim_top_q;
	logic [19:0] gp_up_q, gi_up_q, gd_up_q, gp_dn_q, gi_dn_q, gd_dn_q;

	logic signed [15:0] pos_q, held_q;
	logic [9:0]         dt_q;
	logic signed [7:0]  req_q;
	logic               manual_q;
	logic signed [16:0] err_q, last_q;
	logic signed [39:0] leaky_q;
	logic               down_q;
	logic signed [63:0] acc_q;
	logic signed [48:0] dec_q;
	logic [47:0]        div_n_q;
	logic [9:0]         div_r_q;
	logic               div_neg_q;
	lpp_pkg::lpp_result_t res_q;

	// accept-time decode
	logic signed [7:0]  req_z;
	logic               manual_c;
	logic signed [15:0] t_load, t_lo, t_clamp;

	logic signed [16:0] err_c;
	logic signed [17:0] diff_c;
	logic [19:0]        gp, gi, gd;
	logic signed [20:0] ma, mb;
	logic signed [41:0] prod;
	logic signed [48:0] dec_adj;
	logic signed [41:0] leak_sum;
	logic signed [39:0] leak_sat;
	logic [41:0]        prod_abs;
	logic [10:0]        r1, r2;
	logic [10:0]        r1m, r2m;
	logic               q1, q2;
	logic signed [63:0] acc_adj;
	logic signed [39:0] quot;
	logic signed [7:0]  drv_pid, drv_man, drv, drv_db;
	logic               sat_pid, sat_man;

	always_comb begin
		req_z = tick_data.manual_request;
		if (tick_data.position < lim_bot_q) begin
			if (req_z < 8'sd0)
				req_z = '0;
		end else if (tick_data.position > lim_top_q) begin
			if (req_z > 8'sd0)
				req_z = '0;
		end
		manual_c = (req_z != 8'sd0);
		t_load   = tick_data.load_target ? tick_data.preset_target : held_q;
		t_lo     = (t_load < lim_bot_q) ? lim_bot_q : t_load;
		t_clamp  = (t_lo > lim_top_q) ? lim_top_q : t_lo;
	end

	assign err_c  = {held_q[15], held_q} - {pos_q[15], pos_q};
	assign diff_c = {err_q[16], err_q} - {last_q[16], last_q};
	assign gp = down_q ? gp_dn_q : gp_up_q;
	assign gi = down_q ? gi_dn_q : gi_up_q;
	assign gd = down_q ? gd_dn_q : gd_up_q;

	// shared signed multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			lpp_pkg::OP_DEC_HI: begin
				ma = {leaky_q[39], leaky_q[39:20]};
				mb = 21'(lpp_pkg::DECAY_Q8);
			end
			lpp_pkg::OP_DEC_LO: begin
				ma = {1'b0, leaky_q[19:0]};
				mb = 21'(lpp_pkg::DECAY_Q8);
			end
			lpp_pkg::OP_LEAK: begin
				ma = {{4{err_q[16]}}, err_q};
				mb = {11'b0, dt_q};
			end
			lpp_pkg::OP_P: begin
				ma = {1'b0, gp};
				mb = {{4{err_q[16]}}, err_q};
			end
			lpp_pkg::OP_I_HI: begin
				ma = {1'b0, gi};
				mb = {leaky_q[39], leaky_q[39:20]};
			end
			lpp_pkg::OP_I_LO: begin
				ma = {1'b0, gi};
				mb = {1'b0, leaky_q[19:0]};
			end
			lpp_pkg::OP_D: begin
				ma = {1'b0, gd};
				mb = {{3{diff_c[17]}}, diff_c};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign prod = ma * mb;

	// leaky integral update: decayed sum truncated toward zero plus err*dt in Q8
	always_comb begin
		dec_adj  = dec_q + (dec_q[48] ? 49'sd255 : 49'sd0);
		leak_sum = {dec_adj[48], dec_adj[48:8]} + {prod[33:0], 8'b0};
		if (leak_sum[41:39] == 3'b000 || leak_sum[41:39] == 3'b111)
			leak_sat = leak_sum[39:0];
		else if (leak_sum[41])
			leak_sat = {1'b1, 39'b0};
		else
			leak_sat = {1'b0, {39{1'b1}}};
	end

	assign prod_abs = prod[41] ? (~prod + 42'sd1) : prod;

	// two quotient bits per step
	always_comb begin
		r1  = {div_r_q, div_n_q[47]};
		q1  = (r1 >= {1'b0, dt_q});
		r1m = q1 ? (r1 - {1'b0, dt_q}) : r1;
		r2  = {r1m[9:0], div_n_q[46]};
		q2  = (r2 >= {1'b0, dt_q});
		r2m = q2 ? (r2 - {1'b0, dt_q}) : r2;
	end

	// final scaling, saturation and deadband
	always_comb begin
		acc_adj = acc_q + (acc_q[63] ? 64'sd16777215 : 64'sd0);
		quot    = acc_adj[63:24];
		sat_pid = (quot > 40'sd100) || (quot < -40'sd100);
		if (quot > 40'sd100)
			drv_pid = 8'(lpp_pkg::DRIVE_MAX);
		else if (quot < -40'sd100)
			drv_pid = -8'(lpp_pkg::DRIVE_MAX);
		else
			drv_pid = quot[7:0];
		sat_man = (req_q > 8'sd100) || (req_q < -8'sd100);
		if (req_q > 8'sd100)
			drv_man = 8'(lpp_pkg::DRIVE_MAX);
		else if (req_q < -8'sd100)
			drv_man = -8'(lpp_pkg::DRIVE_MAX);
		else
			drv_man = req_q;
		drv = manual_q ? drv_man : drv_pid;
		if (drv < $signed(8'(lpp_pkg::DEADBAND)) && drv > -$signed(8'(lpp_pkg::DEADBAND)))
			drv_db = '0;
		else
			drv_db = drv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_bot_q <= 16'sd0;
			lim_top_q <= 16'sd8000;
			gp_up_q   <= 20'd5439;
			gi_up_q   <= 20'd721;
			gd_up_q   <= 20'd0;
			gp_dn_q   <= 20'd5177;
			gi_dn_q   <= 20'd524;
			gd_dn_q   <= 20'd0;
		end else if (cfg_we) begin
			unique case (lpp_pkg::cfg_idx_t'(cfg_index))
				lpp_pkg::REG_LIMIT_BOTTOM: lim_bot_q <= cfg_data[15:0];
				lpp_pkg::REG_LIMIT_TOP:    lim_top_q <= cfg_data[15:0];
				lpp_pkg::REG_GAIN_P_UP:    gp_up_q   <= cfg_data;
				lpp_pkg::REG_GAIN_I_UP:    gi_up_q   <= cfg_data;
				lpp_pkg::REG_GAIN_D_UP:    gd_up_q   <= cfg_data;
				lpp_pkg::REG_GAIN_P_DOWN:  gp_dn_q   <= cfg_data;
				lpp_pkg::REG_GAIN_I_DOWN:  gi_dn_q   <= cfg_data;
				lpp_pkg::REG_GAIN_D_DOWN:  gd_dn_q   <= cfg_data;
				default:                   lim_bot_q <= lim_bot_q;
			endcase
		end
	end

	// controller-visible state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			last_q   <= '0;
			leaky_q  <= '0;
			down_q   <= 1'b1;
			manual_q <= 1'b0;
		end else begin
			case (cmd.op)
				lpp_pkg::OP_ACCEPT: begin
					manual_q <= manual_c;
					held_q   <= manual_c ? tick_data.position : t_clamp;
				end
				lpp_pkg::OP_ERR: begin
					if (!manual_q)
						down_q <= (err_c <= 17'sd0);
				end
				lpp_pkg::OP_LEAK: leaky_q <= leak_sat;
				lpp_pkg::OP_D:    last_q  <= err_q;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			lpp_pkg::OP_ACCEPT: begin
				pos_q <= tick_data.position;
				dt_q  <= (tick_data.elapsed_ms == 10'd0) ? 10'd1 : tick_data.elapsed_ms;
				req_q <= req_z;
			end
			lpp_pkg::OP_ERR:    err_q <= err_c;
			lpp_pkg::OP_DEC_HI: dec_q <= {{7{prod[41]}}, prod} <<< 20;
			lpp_pkg::OP_DEC_LO: dec_q <= dec_q + {{7{prod[41]}}, prod};
			lpp_pkg::OP_P:      acc_q <= {{22{prod[41]}}, prod} <<< 8;
			lpp_pkg::OP_I_HI:   acc_q <= acc_q + ({{22{prod[41]}}, prod} <<< 20);
			lpp_pkg::OP_I_LO:   acc_q <= acc_q + {{22{prod[41]}}, prod};
			lpp_pkg::OP_D: begin
				div_n_q   <= {prod_abs[39:0], 8'b0};
				div_r_q   <= '0;
				div_neg_q <= prod[41];
			end
			lpp_pkg::OP_DIV: begin
				div_n_q <= {div_n_q[45:0], q1, q2};
				div_r_q <= r2m[9:0];
			end
			lpp_pkg::OP_ADD_D: begin
				if (div_neg_q)
					acc_q <= acc_q - {16'b0, div_n_q};
				else
					acc_q <= acc_q + {16'b0, div_n_q};
			end
			lpp_pkg::OP_OUT: begin
				res_q.drive_power     <= drv_db;
				res_q.moving_down     <= manual_q ? 1'b0 : down_q;
				res_q.manual_active   <= manual_q;
				res_q.power_saturated <= manual_q ? sat_man : sat_pid;
				res_q.target_now      <= held_q;
			end
			default: ;
		endcase
	end

	assign status.manual = manual_q;
	assign result_data   = res_q;

endmodule

// File: hdl/lpp_ctrl.sv
// Controller of the lift PID: sequences the datapath and owns the handshakes.
module lpp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  tick_valid,
	output logic                  tick_ready,
	output logic                  result_valid,
	input  logic                  result_ready,
	input  lpp_pkg::lpp_status_t  status,
	output lpp_pkg::lpp_cmd_t     cmd
);

	lpp_pkg::state_t state_q, state_d;
	logic [lpp_pkg::DIV_CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lpp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == lpp_pkg::ST_DIV)
				cnt_q <= (cnt_q == lpp_pkg::DIV_CNT_W'(lpp_pkg::DIV_STEPS - 1)) ? '0 : cnt_q + 1'b1;
			if (state_q == lpp_pkg::ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.op     = lpp_pkg::OP_NONE;
		tick_ready = 1'b0;
		unique case (state_q)
			lpp_pkg::ST_IDLE: begin
				tick_ready = 1'b1;
				if (tick_valid) begin
					cmd.op  = lpp_pkg::OP_ACCEPT;
					state_d = lpp_pkg::ST_ERR;
				end
			end
			lpp_pkg::ST_ERR: begin
				cmd.op  = lpp_pkg::OP_ERR;
				state_d = status.manual ? lpp_pkg::ST_OUT : lpp_pkg::ST_DEC_HI;
			end
			lpp_pkg::ST_DEC_HI: begin
				cmd.op  = lpp_pkg::OP_DEC_HI;
				state_d = lpp_pkg::ST_DEC_LO;
			end
			lpp_pkg::ST_DEC_LO: begin
				cmd.op  = lpp_pkg::OP_DEC_LO;
				state_d = lpp_pkg::ST_LEAK;
			end
			lpp_pkg::ST_LEAK: begin
				cmd.op  = lpp_pkg::OP_LEAK;
				state_d = lpp_pkg::ST_P;
			end
			lpp_pkg::ST_P: begin
				cmd.op  = lpp_pkg::OP_P;
				state_d = lpp_pkg::ST_I_HI;
			end
			lpp_pkg::ST_I_HI: begin
				cmd.op  = lpp_pkg::OP_I_HI;
				state_d = lpp_pkg::ST_I_LO;
			end
			lpp_pkg::ST_I_LO: begin
				cmd.op  = lpp_pkg::OP_I_LO;
				state_d = lpp_pkg::ST_D;
			end
			lpp_pkg::ST_D: begin
				cmd.op  = lpp_pkg::OP_D;
				state_d = lpp_pkg::ST_DIV;
			end
			lpp_pkg::ST_DIV: begin
				cmd.op = lpp_pkg::OP_DIV;
				if (cnt_q == lpp_pkg::DIV_CNT_W'(lpp_pkg::DIV_STEPS - 1))
					state_d = lpp_pkg::ST_ADD_D;
			end
			lpp_pkg::ST_ADD_D: begin
				cmd.op  = lpp_pkg::OP_ADD_D;
				state_d = lpp_pkg::ST_OUT;
			end
			lpp_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.op  = lpp_pkg::OP_OUT;
					state_d = lpp_pkg::ST_IDLE;
				end
			end
			default: state_d = lpp_pkg::ST_IDLE;
		endcase
	end

	assign result_valid = out_valid_q;

endmodule
